### sv/m4vt_pkg.sv
// ----------------------------------------------------------------------------
// m4vt_pkg
// Shared types, constants and binary32 helpers for the matrix transform.
// ----------------------------------------------------------------------------
package m4vt_pkg;

  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = 3;
  localparam int REG_W     = 64;
  localparam int FP_W      = 32;
  localparam int LANES     = 4;
  localparam int MUL_LAT   = 5;
  localparam int ADD_LAT   = 6;
  localparam int LANE_LAT  = MUL_LAT + 3 * ADD_LAT;

  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [31:0] INF_BITS  = 32'h7F80_0000;

  typedef logic [FP_W-1:0] fp_t;

  // rounder input: exact value m * 2^e with sign, or a ready special result
  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_val;
    logic               sign;
    logic signed [10:0] e;
    logic [47:0]        m;
  } rnd_in_t;

  typedef struct packed {
    logic [23:0]        m;
    logic signed [10:0] e;
  } unp_t;

  function automatic logic is_nan(input fp_t a);
    is_nan = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
  endfunction

  function automatic logic is_inf(input fp_t a);
    is_inf = (a[30:0] == INF_BITS[30:0]);
  endfunction

  function automatic logic is_zero(input fp_t a);
    is_zero = (a[30:0] == 31'd0);
  endfunction

  function automatic unp_t unpack(input fp_t a);
    unp_t u;
    if (a[30:23] == 8'd0) begin
      u.m = {1'b0, a[22:0]};
      u.e = -11'sd149;
    end else begin
      u.m = {1'b1, a[22:0]};
      u.e = $signed({3'b000, a[30:23]}) - 11'sd150;
    end
    unpack = u;
  endfunction

endpackage

### sv/matrix4_vector_transform.sv
// ----------------------------------------------------------------------------
// matrix4_vector_transform
// Pipeline: 23 lane stages plus the output register; throughput one vector
//   per cycle while the output is not stalled.
// Four row lanes run in parallel; the whole pipeline holds while a result
//   waits at the output. Reset (rst_n, synchronous) clears the matrix to
//   zero and empties the pipeline.
// ----------------------------------------------------------------------------
module matrix4_vector_transform (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [m4vt_pkg::REG_IDX_W-1:0]  cfg_index,
  input  logic [m4vt_pkg::REG_W-1:0]      cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [127:0]                    in_tdata,  // vec_x, vec_y, vec_z, vec_w
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [127:0]                    out_tdata  // out_x, out_y, out_z, out_w
);
  import m4vt_pkg::*;

  logic [REG_W-1:0] regs_r [NUM_REGS];
  logic [LANE_LAT-1:0] vld_r;
  logic           out_valid_r;
  logic [127:0]   out_data_r;
  logic           en;
  fp_t            vec [LANES];
  fp_t            lane_res [LANES];

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) regs_r[i] <= '0;
    end else if (cfg_we) begin
      regs_r[cfg_index] <= cfg_wdata;
    end
  end

  for (genvar c = 0; c < LANES; c++) begin : g_vec
    assign vec[c] = in_tdata[c*FP_W +: FP_W];
  end

  for (genvar r = 0; r < LANES; r++) begin : g_lane
    fp_t row [LANES];
    for (genvar c = 0; c < LANES; c++) begin : g_col
      assign row[c] = regs_r[r*2 + c/2][(c%2)*FP_W +: FP_W];
    end
    m4vt_lane u_lane (
      .clk (clk),
      .en  (en),
      .row (row),
      .vec (vec),
      .res (lane_res[r])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[LANE_LAT-2:0], in_tvalid};
      out_valid_r <= vld_r[LANE_LAT-1];
    end
  end

  // merge the four lanes into one beat
  always_ff @(posedge clk) begin
    if (en) out_data_r <= {lane_res[3], lane_res[2], lane_res[1], lane_res[0]};
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_rise_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(vld_r[LANE_LAT-1]))
    else $error("output valid without an item leaving the lanes");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(vld_r))
    else $error("lane pipeline moved while output stalled");

  a_canonical_nan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r[30:23] == 8'hFF && out_data_r[22:0] != 23'd0)
      |-> out_data_r[31:0] == QNAN_BITS)
    else $error("non-canonical NaN on out_x");

endmodule

### sv/m4vt_round.sv
// ----------------------------------------------------------------------------
// m4vt_round
// Four-stage normalize and round-to-nearest-even pack to binary32.
// ----------------------------------------------------------------------------
module m4vt_round (
  input  logic              clk,
  input  logic              en,
  input  m4vt_pkg::rnd_in_t rin,
  output m4vt_pkg::fp_t     res
);
  import m4vt_pkg::*;

  // stage 1: leading one position
  logic [5:0]         p_nxt;
  rnd_in_t            s1_r;
  logic [5:0]         p_r;

  always_comb begin
    p_nxt = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (rin.m[i]) p_nxt = 6'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= rin;
      p_r  <= p_nxt;
    end
  end

  // stage 2: normalize, biased exponent, subnormal shift
  logic signed [10:0] be_nxt;
  logic signed [10:0] dn_nxt;
  logic [5:0]         rsh_nxt;
  logic [47:0]        n_nxt;
  logic [47:0]        n_r;
  logic signed [10:0] be_r;
  logic [5:0]         rsh_r;
  logic               s2_spec_r;
  logic [31:0]        s2_val_r;
  logic               s2_sign_r;

  always_comb begin
    n_nxt  = s1_r.m << (6'd47 - p_r);
    be_nxt = $signed({5'b00000, p_r}) + s1_r.e + 11'sd127;
    dn_nxt = 11'sd1 - be_nxt;
    if (be_nxt >= 11'sd1) rsh_nxt = 6'd0;
    else if (dn_nxt > 11'sd48) rsh_nxt = 6'd48;
    else rsh_nxt = dn_nxt[5:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r       <= n_nxt;
      be_r      <= be_nxt;
      rsh_r     <= rsh_nxt;
      s2_spec_r <= s1_r.spec;
      s2_val_r  <= s1_r.spec_val;
      s2_sign_r <= s1_r.sign;
    end
  end

  // stage 3: right shift into subnormal range, collect sticky
  logic [47:0] sh_nxt;
  logic [47:0] mask_nxt;
  logic [23:0] keep_r;
  logic        g_r;
  logic        st_r;
  logic [7:0]  base_r;
  logic        ovf_r;
  logic        s3_spec_r;
  logic [31:0] s3_val_r;
  logic        s3_sign_r;

  always_comb begin
    sh_nxt   = n_r >> rsh_r;
    mask_nxt = (48'd1 << rsh_r) - 48'd1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      keep_r    <= sh_nxt[47:24];
      g_r       <= sh_nxt[23];
      st_r      <= (|sh_nxt[22:0]) | (|(n_r & mask_nxt));
      base_r    <= (be_r > 11'sd1) ? (be_r[7:0] - 8'd1) : 8'd0;
      ovf_r     <= (be_r > 11'sd254);
      s3_spec_r <= s2_spec_r;
      s3_val_r  <= s2_val_r;
      s3_sign_r <= s2_sign_r;
    end
  end

  // stage 4: round and pack
  logic        inc;
  logic [31:0] bits;
  logic [31:0] res_nxt;
  logic [31:0] res_r;

  always_comb begin
    inc  = g_r & (st_r | keep_r[0]);
    bits = {1'b0, base_r, 23'd0} + {8'd0, keep_r} + {31'd0, inc};
    if (s3_spec_r) res_nxt = s3_val_r;
    else if (ovf_r || bits >= INF_BITS) res_nxt = {s3_sign_r, INF_BITS[30:0]};
    else res_nxt = {s3_sign_r, bits[30:0]};
  end

  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

### sv/m4vt_fmul.sv
// ----------------------------------------------------------------------------
// m4vt_fmul
// Pipelined binary32 multiply: product register, then its own m4vt_round rounder.
// ----------------------------------------------------------------------------
module m4vt_fmul (
  input  logic          clk,
  input  logic          en,
  input  m4vt_pkg::fp_t a,
  input  m4vt_pkg::fp_t b,
  output m4vt_pkg::fp_t res
);
  import m4vt_pkg::*;

  unp_t    ua;
  unp_t    ub;
  logic    sign;
  rnd_in_t rin_nxt;
  rnd_in_t rin_r;

  always_comb begin
    ua   = unpack(a);
    ub   = unpack(b);
    sign = a[31] ^ b[31];
    rin_nxt.sign     = sign;
    rin_nxt.e        = ua.e + ub.e;
    rin_nxt.m        = ua.m * ub.m;
    rin_nxt.spec     = 1'b1;
    rin_nxt.spec_val = QNAN_BITS;
    if (is_nan(a) || is_nan(b)) begin
      rin_nxt.spec_val = QNAN_BITS;
    end else if (is_inf(a) || is_inf(b)) begin
      rin_nxt.spec_val = (is_zero(a) || is_zero(b)) ? QNAN_BITS :
                         {sign, INF_BITS[30:0]};
    end else if (is_zero(a) || is_zero(b)) begin
      rin_nxt.spec_val = {sign, 31'd0};
    end else begin
      rin_nxt.spec = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) rin_r <= rin_nxt;
  end

  m4vt_round u_round (
    .clk (clk),
    .en  (en),
    .rin (rin_r),
    .res (res)
  );

endmodule

### sv/m4vt_fadd.sv
// ----------------------------------------------------------------------------
// m4vt_fadd
// Pipelined binary32 add: swap, align and add, then its own m4vt_round rounder.
// ----------------------------------------------------------------------------
module m4vt_fadd (
  input  logic          clk,
  input  logic          en,
  input  m4vt_pkg::fp_t a,
  input  m4vt_pkg::fp_t b,
  output m4vt_pkg::fp_t res
);
  import m4vt_pkg::*;

  // stage 1: specials and swap by exponent
  unp_t               ua;
  unp_t               ub;
  logic               swap;
  logic signed [10:0] d;
  logic               spec_nxt;
  logic [31:0]        val_nxt;

  logic               spec1_r;
  logic [31:0]        val1_r;
  logic [23:0]        mbig_r;
  logic [23:0]        msml_r;
  logic               sbig_r;
  logic               ssml_r;
  logic signed [10:0] ebig_r;
  logic [4:0]         dc_r;

  always_comb begin
    ua       = unpack(a);
    ub       = unpack(b);
    swap     = (ua.e < ub.e);
    d        = swap ? (ub.e - ua.e) : (ua.e - ub.e);
    spec_nxt = 1'b1;
    val_nxt  = QNAN_BITS;
    if (is_nan(a) || is_nan(b)) begin
      val_nxt = QNAN_BITS;
    end else if (is_inf(a) && is_inf(b)) begin
      val_nxt = (a[31] == b[31]) ? a : QNAN_BITS;
    end else if (is_inf(a)) begin
      val_nxt = a;
    end else if (is_inf(b)) begin
      val_nxt = b;
    end else if (is_zero(a) && is_zero(b)) begin
      val_nxt = {a[31] & b[31], 31'd0};
    end else if (is_zero(a)) begin
      val_nxt = b;
    end else if (is_zero(b)) begin
      val_nxt = a;
    end else begin
      spec_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      spec1_r <= spec_nxt;
      val1_r  <= val_nxt;
      mbig_r  <= swap ? ub.m : ua.m;
      msml_r  <= swap ? ua.m : ub.m;
      sbig_r  <= swap ? b[31] : a[31];
      ssml_r  <= swap ? a[31] : b[31];
      ebig_r  <= swap ? ub.e : ua.e;
      dc_r    <= (d > 11'sd27) ? 5'd27 : d[4:0];
    end
  end

  // stage 2: align with three guard bits, add or subtract
  logic [26:0] big;
  logic [26:0] sml_full;
  logic [26:0] sml;
  logic [26:0] mask;
  logic [27:0] sum;
  logic [27:0] dif;
  rnd_in_t     rin_nxt;
  rnd_in_t     rin_r;

  always_comb begin
    big      = {mbig_r, 3'b000};
    sml_full = {msml_r, 3'b000};
    mask     = (27'd1 << dc_r) - 27'd1;
    sml      = (sml_full >> dc_r) | {26'd0, |(sml_full & mask)};
    sum      = {1'b0, big} + {1'b0, sml};
    dif      = {1'b0, big} - {1'b0, sml};
    rin_nxt.spec     = spec1_r;
    rin_nxt.spec_val = val1_r;
    rin_nxt.e        = ebig_r - 11'sd3;
    rin_nxt.sign     = sbig_r;
    rin_nxt.m        = {20'd0, sum};
    if (sbig_r != ssml_r) begin
      if (dif == 28'd0) begin
        rin_nxt.spec     = 1'b1;
        rin_nxt.spec_val = spec1_r ? val1_r : 32'd0;
      end else if (dif[27]) begin
        // exponents were equal and the other operand held the larger magnitude
        rin_nxt.m    = {20'd0, 28'd0 - dif};
        rin_nxt.sign = ssml_r;
      end else begin
        rin_nxt.m = {20'd0, dif};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) rin_r <= rin_nxt;
  end

  m4vt_round u_round (
    .clk (clk),
    .en  (en),
    .rin (rin_r),
    .res (res)
  );

endmodule

### sv/m4vt_lane.sv
// ----------------------------------------------------------------------------
// m4vt_lane
// One matrix row: four multipliers and a chain of three adders.
// ----------------------------------------------------------------------------
module m4vt_lane (
  input  logic          clk,
  input  logic          en,
  input  m4vt_pkg::fp_t row [m4vt_pkg::LANES],
  input  m4vt_pkg::fp_t vec [m4vt_pkg::LANES],
  output m4vt_pkg::fp_t res
);
  import m4vt_pkg::*;

  fp_t prod [LANES];
  fp_t s1;
  fp_t s2;
  fp_t p2_r [ADD_LAT];
  fp_t p3_r [2*ADD_LAT];

  for (genvar c = 0; c < LANES; c++) begin : g_mul
    m4vt_fmul u_mul (
      .clk (clk),
      .en  (en),
      .a   (row[c]),
      .b   (vec[c]),
      .res (prod[c])
    );
  end

  // hold later products until the running sum catches up
  always_ff @(posedge clk) begin
    if (en) begin
      p2_r[0] <= prod[2];
      for (int i = 1; i < ADD_LAT; i++) p2_r[i] <= p2_r[i-1];
      p3_r[0] <= prod[3];
      for (int i = 1; i < 2*ADD_LAT; i++) p3_r[i] <= p3_r[i-1];
    end
  end

  m4vt_fadd u_add0 (.clk(clk), .en(en), .a(prod[0]), .b(prod[1]), .res(s1));
  m4vt_fadd u_add1 (.clk(clk), .en(en), .a(s1), .b(p2_r[ADD_LAT-1]), .res(s2));
  m4vt_fadd u_add2 (.clk(clk), .en(en), .a(s2), .b(p3_r[2*ADD_LAT-1]), .res(res));

endmodule
